/* rtl/vpth_pkg.sv */
// Shared widths, types, rounding multiply and the power-of-ten table for the vapor pressure unit.
package vpth_pkg;

    // Port field widths.
    localparam int TEMP_W = 14;
    localparam int RH_W   = 14;
    localparam int VP_W   = 16;

    // Divider geometry: numerator, denominator and quotient widths.
    localparam int NW         = 44;
    localparam int DEN_W      = 25;
    localparam int QW         = 22;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = QW / DIV_STEP;

    // Exponent width in Q16, signed.
    localparam int XW = QW + 1;

    // Control that travels with one transfer through the divider.
    typedef struct packed {
        logic valid;
        logic neg;
    } div_ctl_t;

    // 10^(k/16) in Q16 for k = 0..16.
    localparam logic [19:0] POW10_TAB [17] = '{
        20'd65536,  20'd75680,  20'd87394,  20'd100921, 20'd116541, 20'd134580,
        20'd155410, 20'd179465, 20'd207243, 20'd239321, 20'd276363, 20'd319139,
        20'd368536, 20'd425579, 20'd491451, 20'd567518, 20'd655360
    };

    // Q16 product, rounded to nearest with ties away from zero.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        logic signed [63:0] prod;
        logic [63:0]        mag;
        logic [63:0]        q;
        prod = 64'(x) * 64'(y);
        mag  = prod[63] ? 64'(-prod) : 64'(prod);
        q    = (mag + 64'd32768) >> 16;
        qmul = prod[63] ? -$signed(q[31:0]) : $signed(q[31:0]);
    endfunction

endpackage

/* rtl/vpth_div.sv */
// Pipelined restoring divider, two quotient bits per stage.
module vpth_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vpth_pkg::div_ctl_t           ctl_in,
    input  logic [vpth_pkg::NW-1:0]      numer,
    input  logic [vpth_pkg::DEN_W-1:0]   denom,
    output vpth_pkg::div_ctl_t           ctl_out,
    output logic [vpth_pkg::QW-1:0]      quot
);

    localparam int STAGES = vpth_pkg::DIV_STAGES;
    localparam int DW     = vpth_pkg::DEN_W;
    localparam int QB     = vpth_pkg::QW;

    logic [DW-1:0]      rem_reg  [STAGES];
    logic [DW-1:0]      rem_next [STAGES];
    logic [QB-1:0]      nq_reg   [STAGES];
    logic [QB-1:0]      nq_next  [STAGES];
    logic [DW-1:0]      den_reg  [STAGES];
    vpth_pkg::div_ctl_t ctl_reg  [STAGES];

    // Remainder and quotient sources for each stage.
    logic [DW-1:0] rem_src [STAGES];
    logic [QB-1:0] nq_src  [STAGES];
    logic [DW-1:0] den_src [STAGES];

    always_comb
    begin
        rem_src[0] = DW'(numer[vpth_pkg::NW-1:QB]);
        nq_src[0]  = numer[QB-1:0];
        den_src[0] = denom;
        for (int s = 1; s < STAGES; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            nq_src[s]  = nq_reg[s-1];
            den_src[s] = den_reg[s-1];
        end
    end

    // Shift-subtract steps. The quotient bits enter at the bottom of the
    // register that still holds the unused numerator bits at its top.
    always_comb
    begin
        logic [DW:0]   trial;
        logic [DW-1:0] rem;
        logic [QB-1:0] nq;
        trial = '0;
        rem   = '0;
        nq    = '0;
        for (int s = 0; s < STAGES; s++)
        begin
            rem = rem_src[s];
            nq  = nq_src[s];
            for (int k = 0; k < vpth_pkg::DIV_STEP; k++)
            begin
                trial = {rem, nq[QB-1]};
                nq    = {nq[QB-2:0], 1'b0};
                if (trial >= {1'b0, den_src[s]})
                begin
                    trial = trial - {1'b0, den_src[s]};
                    nq[0] = 1'b1;
                end
                rem = trial[DW-1:0];
            end
            rem_next[s] = rem;
            nq_next[s]  = nq;
        end
    end

    // Valid and sign travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s < STAGES; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            nq_reg[s]  <= nq_next[s];
            den_reg[s] <= den_src[s];
        end
    end

    assign ctl_out = ctl_reg[STAGES-1];
    assign quot    = nq_reg[STAGES-1];

    // A valid transfer comes out at the end of the divider stages.
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.valid |-> ##STAGES ctl_out.valid)
        else $error("divider lost a transfer");

    // The final remainder is always below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_out.valid |-> (rem_reg[STAGES-1] < den_reg[STAGES-1]))
        else $error("divider remainder out of range");

endmodule

/* rtl/vpth_exp10.sv */
// Pipelined 6.11 * 10^x stage with table interpolation, scaling and saturation.
module vpth_exp10 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [vpth_pkg::XW-1:0]  x,
    output logic                            out_valid,
    output logic [vpth_pkg::VP_W-1:0]       value
);

    // Result classes decided from the integer part of the exponent.
    localparam logic [1:0] CLS_POS  = 2'd0;
    localparam logic [1:0] CLS_NEG  = 2'd1;
    localparam logic [1:0] CLS_SAT  = 2'd2;
    localparam logic [1:0] CLS_ZERO = 2'd3;

    // Scale by 10^n for n = 0..2, and round-then-divide by 10^k for k = 1..4.
    localparam logic [6:0]  SCALE [4] = '{7'd1, 7'd10, 7'd100, 7'd1};
    localparam logic [29:0] HALF  [4] = '{30'd327680, 30'd3276800, 30'd32768000,
                                         30'd327680000};
    localparam logic [14:0] RECIP [4] = '{15'd26215, 15'd20972, 15'd16778, 15'd26844};
    localparam logic [4:0]  SHIFT [4] = '{5'd18, 5'd21, 5'd24, 5'd28};

    logic [4:0]  vld_reg;

    logic [19:0] m_reg, m_next;
    logic [1:0]  cls1_reg, cls1_next, sel1_reg, sel1_next;
    logic [28:0] p_reg, p_next;
    logic [1:0]  cls2_reg, sel2_reg;
    logic [35:0] ps_reg, ps_next;
    logic [13:0] v_reg, v_next;
    logic [1:0]  cls3_reg, sel3_reg;
    logic [19:0] pos_reg, pos_next;
    logic [13:0] neg_reg, neg_next;
    logic [1:0]  cls4_reg;
    logic [15:0] value_reg, value_next;

    logic signed [6:0] n_int;
    logic [3:0]        f_idx;
    logic [11:0]       f_rem;
    logic [4:0]        idx_lo, idx_hi;
    logic [19:0]       tab_lo;
    logic [16:0]       tab_diff;
    logic [28:0]       lerp_prod;
    logic [29:0]       lerp_rnd;
    logic [29:0]       half_sum;
    logic [28:0]       recip_prod;

    // First stage: table lookup and linear interpolation of the mantissa.
    assign n_int     = x[vpth_pkg::XW-1:16];
    assign f_idx     = x[15:12];
    assign f_rem     = x[11:0];
    assign idx_lo    = {1'b0, f_idx};
    assign idx_hi    = idx_lo + 5'd1;
    assign tab_lo    = vpth_pkg::POW10_TAB[idx_lo];
    assign tab_diff  = 17'(vpth_pkg::POW10_TAB[idx_hi] - tab_lo);
    assign lerp_prod = tab_diff * f_rem;
    assign lerp_rnd  = 30'(lerp_prod) + 30'd2048;
    assign m_next    = tab_lo + 20'(lerp_rnd[29:12]);

    always_comb
    begin
        if (n_int > 7'sd2)
        begin
            cls1_next = CLS_SAT;
        end
        else if (n_int < -7'sd4)
        begin
            cls1_next = CLS_ZERO;
        end
        else if (!n_int[6])
        begin
            cls1_next = CLS_POS;
        end
        else
        begin
            cls1_next = CLS_NEG;
        end
        sel1_next = n_int[6] ? ~n_int[1:0] : n_int[1:0];
    end

    // Second stage: multiply by 6.11 mbar in 0.01 mbar units.
    assign p_next = 29'(m_reg * 10'd611);

    // Third stage: scale up, or add half the divisor for the rounded divide.
    assign ps_next  = 36'(p_reg * SCALE[sel2_reg]);
    assign half_sum = 30'(p_reg) + HALF[sel2_reg];
    assign v_next   = half_sum[29:16];

    // Fourth stage: drop the Q16 fraction, or divide by 10^k via reciprocal.
    assign pos_next   = 20'((ps_reg + 36'd32768) >> 16);
    assign recip_prod = v_reg * RECIP[sel3_reg];
    assign neg_next   = 14'(recip_prod >> SHIFT[sel3_reg]);

    // Fifth stage: select and saturate.
    always_comb
    begin
        case (cls4_reg)
            CLS_POS:
            begin
                value_next = (pos_reg > 20'd65535) ? 16'hFFFF : pos_reg[15:0];
            end
            CLS_NEG:
            begin
                value_next = 16'(neg_reg);
            end
            CLS_SAT:
            begin
                value_next = 16'hFFFF;
            end
            default:
            begin
                value_next = 16'd0;
            end
        endcase
    end

    // Valid shift line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        cls1_reg  <= cls1_next;
        sel1_reg  <= sel1_next;
        p_reg     <= p_next;
        cls2_reg  <= cls1_reg;
        sel2_reg  <= sel1_reg;
        ps_reg    <= ps_next;
        v_reg     <= v_next;
        cls3_reg  <= cls2_reg;
        sel3_reg  <= sel2_reg;
        pos_reg   <= pos_next;
        neg_reg   <= neg_next;
        cls4_reg  <= cls3_reg;
        value_reg <= value_next;
    end

    assign out_valid = vld_reg[4];
    assign value     = value_reg;

    // A large exponent always gives the full-scale result.
    a_exp_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && cls4_reg == CLS_SAT) |=> (out_valid && value == 16'hFFFF))
        else $error("saturated exponent did not give full scale");

    // A very negative exponent always gives zero.
    a_exp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && cls4_reg == CLS_ZERO) |=> (out_valid && value == 16'd0))
        else $error("tiny exponent did not give zero");

endmodule

/* rtl/vapor_pressure_from_temp_humidity_unit.sv */
// Top level of the vapor pressure unit: input scaling, dewpoint polynomial, divide, exp10.
//
//   Channel   Handshake          Payload
//   command   start / busy       temp_centi (s14, 0.01 C), rel_humidity (u14, 0.01 %)
//   result    done (one cycle)   vapor_pressure (u16, 0.01 mbar)
//
// One sample is taken in every cycle; busy is never raised.
// Each result appears once its command transfer has passed through the
// eleven front stages, the eleven divider stages, the exponent register
// and the five exp10 stages.
// Reset clears only the valid bits and divider sign bits; data registers are free.
// The receiver cannot stall, so results leave in order and nothing waits.
module vapor_pressure_from_temp_humidity_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [vpth_pkg::TEMP_W-1:0] temp_centi,
    input  logic [vpth_pkg::RH_W-1:0]          rel_humidity,
    output logic                               done,
    output logic [vpth_pkg::VP_W-1:0]          vapor_pressure
);

    localparam int LATENCY = 11 + vpth_pkg::DIV_STAGES + 1 + 5;
    localparam int NW      = vpth_pkg::NW;
    localparam int DW      = vpth_pkg::DEN_W;
    localparam int XW      = vpth_pkg::XW;

    // Reciprocals for exact division by 100 and by 10000.
    localparam logic [30:0] T_RECIP = 31'd1374389535;
    localparam logic [29:0] A_RECIP = 30'd879609303;

    logic [10:0] vld_reg;

    // Stage 1: input scaling to Q16.
    logic [13:0] tc_mag;
    logic [29:0] t_num, a_num;
    logic [60:0] t_prod;
    logic [59:0] a_prod;
    logic [23:0] t_mag_reg, t_mag_next;
    logic        t_neg_reg, t_neg_next;
    logic [16:0] aq_reg, aq_next;

    // Stage 2.
    logic signed [23:0] t_reg, t_next;
    logic signed [17:0] a_reg, a_next;

    // Stage 3.
    logic signed [17:0] a2_reg, a2_next;
    logic signed [21:0] k1_reg, k1_next;
    logic signed [18:0] k2_reg, k2_next;
    logic signed [21:0] k3_reg, k3_next;
    logic signed [23:0] t3_reg;
    logic signed [17:0] a3_reg;

    // Stage 4.
    logic signed [17:0] a4_reg, a4_next, a2_4_reg;
    logic signed [23:0] u1_reg, u1_next;
    logic signed [18:0] c_reg, c_next;
    logic signed [21:0] k3_4_reg;
    logic signed [23:0] t4_reg;

    // Stage 5.
    logic signed [17:0] a8_reg, a8_next, a4_5_reg, a2_5_reg;
    logic signed [21:0] cc_reg, cc_next;
    logic signed [18:0] c5_reg;
    logic signed [25:0] tu_reg, tu_next;
    logic signed [21:0] k3_5_reg;

    // Stage 6.
    logic signed [17:0] a12_reg, a12_next, a2_6_reg;
    logic signed [23:0] c3_reg, c3_next;
    logic signed [25:0] tu6_reg;
    logic signed [21:0] k3_6_reg;

    // Stage 7.
    logic signed [17:0] a14_reg, a14_next;
    logic signed [25:0] b0_reg, b0_next;
    logic signed [21:0] k3_7_reg;

    // Stage 8.
    logic signed [23:0] u3_reg, u3_next;
    logic signed [25:0] b0_8_reg;

    // Stage 9.
    logic signed [25:0] b_reg, b_next;

    // Stage 10.
    logic signed [27:0] num_reg, num_next;
    logic signed [26:0] den_sum;
    logic [DW-1:0]      den_reg, den_next;

    // Stage 11.
    logic [27:0]        num_mag;
    logic [NW-1:0]      numer_reg, numer_next;
    logic [DW-1:0]      den11_reg;
    logic               neg_reg;

    // Divider and exponent.
    vpth_pkg::div_ctl_t      div_in, div_out;
    logic [vpth_pkg::QW-1:0] quot;
    logic signed [XW-1:0]    q_s;
    logic signed [XW-1:0]    x_reg, x_next;
    logic                    x_vld_reg;

    assign busy = 1'b0;

    // Stage 1: rounded divide of the inputs by 100 and 10000.
    assign tc_mag     = temp_centi[13] ? 14'(-temp_centi) : 14'(temp_centi);
    assign t_num      = {tc_mag, 16'b0} + 30'd50;
    assign t_prod     = t_num * T_RECIP;
    assign t_mag_next = t_prod[60:37];
    assign t_neg_next = temp_centi[13];
    assign a_num      = {rel_humidity, 16'b0} + 30'd5000;
    assign a_prod     = a_num * A_RECIP;
    assign aq_next    = a_prod[59:43];

    // Stage 2: signed temperature and dryness term.
    assign t_next = t_neg_reg ? -$signed(t_mag_reg) : $signed(t_mag_reg);
    assign a_next = 18'sd65536 - $signed({1'b0, aq_reg});

    // Stage 3: square of the dryness and the temperature coefficients.
    assign a2_next = 18'(vpth_pkg::qmul(32'(a_reg), 32'(a_reg)));
    assign k1_next = 22'(32'sd953549 + vpth_pkg::qmul(32'sd7471, 32'(t_reg)));
    assign k2_next = 19'(32'sd163840 + vpth_pkg::qmul(32'sd459, 32'(t_reg)));
    assign k3_next = 22'(32'sd1042022 + vpth_pkg::qmul(32'sd7668, 32'(t_reg)));

    // Stage 4: fourth power of the dryness, linear term and cube base.
    assign a4_next = 18'(vpth_pkg::qmul(32'(a2_reg), 32'(a2_reg)));
    assign u1_next = 24'(vpth_pkg::qmul(32'(k1_reg), 32'(a3_reg)));
    assign c_next  = 19'(vpth_pkg::qmul(32'(k2_reg), 32'(a3_reg)));

    // Stage 5.
    assign a8_next = 18'(vpth_pkg::qmul(32'(a4_reg), 32'(a4_reg)));
    assign cc_next = 22'(vpth_pkg::qmul(32'(c_reg), 32'(c_reg)));
    assign tu_next = 26'(t4_reg) - 26'(u1_reg);

    // Stage 6.
    assign a12_next = 18'(vpth_pkg::qmul(32'(a8_reg), 32'(a4_5_reg)));
    assign c3_next  = 24'(vpth_pkg::qmul(32'(cc_reg), 32'(c5_reg)));

    // Stage 7.
    assign a14_next = 18'(vpth_pkg::qmul(32'(a12_reg), 32'(a2_6_reg)));
    assign b0_next  = tu6_reg - 26'(c3_reg);

    // Stage 8: fourteenth-power term.
    assign u3_next = 24'(vpth_pkg::qmul(32'(k3_7_reg), 32'(a14_reg)));

    // Stage 9: dewpoint-like value.
    assign b_next = b0_8_reg - 26'(u3_reg);

    // Stage 10: numerator and clamped denominator of the exponent.
    assign num_next = 28'(vpth_pkg::qmul(32'sd491520, 32'(b_reg)));
    assign den_sum  = 27'(b_reg) + 27'sd15577907;
    assign den_next = (den_sum < 27'sd65536) ? DW'(65536) : den_sum[DW-1:0];

    // Stage 11: magnitude numerator with half the divisor added for rounding.
    assign num_mag    = num_reg[27] ? 28'(-num_reg) : 28'(num_reg);
    assign numer_next = (NW'(num_mag) << 16) + NW'(den_reg[DW-1:1]);

    assign div_in = '{valid: vld_reg[10], neg: neg_reg};

    vpth_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (div_in),
        .numer   (numer_reg),
        .denom   (den11_reg),
        .ctl_out (div_out),
        .quot    (quot)
    );

    // Restore the sign of the exponent.
    assign q_s    = $signed({1'b0, quot});
    assign x_next = div_out.neg ? -q_s : q_s;

    vpth_exp10 u_exp10 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x_vld_reg),
        .x         (x_reg),
        .out_valid (done),
        .value     (vapor_pressure)
    );

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            x_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= {vld_reg[9:0], start & ~busy};
            x_vld_reg <= div_out.valid;
        end
    end

    // Front stage payload.
    always_ff @(posedge clk)
    begin
        t_mag_reg <= t_mag_next;
        t_neg_reg <= t_neg_next;
        aq_reg    <= aq_next;

        t_reg     <= t_next;
        a_reg     <= a_next;

        a2_reg    <= a2_next;
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        k3_reg    <= k3_next;
        t3_reg    <= t_reg;
        a3_reg    <= a_reg;

        a4_reg    <= a4_next;
        a2_4_reg  <= a2_reg;
        u1_reg    <= u1_next;
        c_reg     <= c_next;
        k3_4_reg  <= k3_reg;
        t4_reg    <= t3_reg;

        a8_reg    <= a8_next;
        a4_5_reg  <= a4_reg;
        a2_5_reg  <= a2_4_reg;
        cc_reg    <= cc_next;
        c5_reg    <= c_reg;
        tu_reg    <= tu_next;
        k3_5_reg  <= k3_4_reg;

        a12_reg   <= a12_next;
        a2_6_reg  <= a2_5_reg;
        c3_reg    <= c3_next;
        tu6_reg   <= tu_reg;
        k3_6_reg  <= k3_5_reg;

        a14_reg   <= a14_next;
        b0_reg    <= b0_next;
        k3_7_reg  <= k3_6_reg;

        u3_reg    <= u3_next;
        b0_8_reg  <= b0_reg;

        b_reg     <= b_next;

        num_reg   <= num_next;
        den_reg   <= den_next;

        numer_reg <= numer_next;
        den11_reg <= den_reg;
        neg_reg   <= num_reg[27];

        x_reg     <= x_next;
    end

    // Every command transfer produces exactly one result at the end of the pipeline.
    a_top_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result missing for a command transfer");

    // No result appears without a matching command transfer.
    a_top_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result without a command transfer");

endmodule
